@@ design/bsa_pkg.sv @@
// Shared types, constants and the tone curve table of the splat accumulator.
`default_nettype none

package bsa_pkg;

    localparam int IMG_WIDTH_DEF  = 480;
    localparam int IMG_HEIGHT_DEF = 360;

    localparam int POS_W     = 17;
    localparam int COLOR_W   = 16;
    localparam int WEIGHT_W  = 16;
    localparam int PIXIDX_W  = 18;
    localparam int FRAC_W    = 8;
    localparam int INT_W     = POS_W - FRAC_W;
    localparam int SUM_W     = 32;
    localparam int BYTE_W    = 8;
    localparam int CH_NUM    = 3;
    localparam int WORD_W    = CH_NUM * SUM_W;
    localparam int CW_W      = COLOR_W + WEIGHT_W;        // colour times weight
    localparam int CORNER_W  = 2 * (FRAC_W + 1) - 1;      // bilinear weight, max 2^16
    localparam int PROD_W    = CW_W + CORNER_W;

    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 24;

    localparam int TONE_LEN     = 1024;
    localparam int TONE_IDX_W   = 10;
    localparam logic [TONE_IDX_W-1:0] TONE_MAX_IDX = TONE_IDX_W'(TONE_LEN - 1);
    localparam int TONE_SHIFT   = 16;

    // func codes
    localparam logic FUNC_SPLAT = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // exp(-11/2560): five series terms in Q0.40, truncated at each step
    localparam logic [63:0] TONE_T1 = ((64'd1 << 40) * 64'd11) / 64'd2560;
    localparam logic [63:0] TONE_T2 = (TONE_T1 * 64'd11) / 64'd5120;
    localparam logic [63:0] TONE_T3 = (TONE_T2 * 64'd11) / 64'd7680;
    localparam logic [63:0] TONE_T4 = (TONE_T3 * 64'd11) / 64'd10240;
    localparam logic [63:0] TONE_T5 = (TONE_T4 * 64'd11) / 64'd12800;
    localparam logic [63:0] TONE_E  = (64'd1 << 40) - TONE_T1 + TONE_T2 - TONE_T3
                                      + TONE_T4 - TONE_T5;
    // ratio rounded to Q0.32
    localparam logic [63:0] TONE_R  = (TONE_E + 64'd128) >> 8;

    // sequencer to datapath controls
    typedef struct packed {
        logic       load;       // capture splat operands
        logic       mul_en;     // form corner products
        logic [1:0] corner;     // corner being read
        logic       acc_we;     // write back accumulated word
        logic       zero_we;    // write zero word (clear pass, readout)
        logic       tone_en;    // look up tone bytes into output register
        logic       oor;        // readout index past the image
    } t_seq_ctl;

    typedef logic [BYTE_W-1:0] t_tone_rom [0:TONE_LEN-1];

    // exp curve, evaluated at elaboration only
    function automatic t_tone_rom f_tone_curve();
        logic [63:0] v;
        logic [63:0] t;
        t_tone_rom   rom;
        v = 64'd1 << 32;
        for (int i = 0; i < TONE_LEN; i++) begin
            if (i != 0) begin
                v = (v * TONE_R + (64'd1 << 31)) >> 32;
            end
            t = (64'd255 * ((64'd1 << 32) - v)) >> 32;
            rom[i] = (t > 64'd255) ? 8'hFF : t[7:0];
        end
        return rom;
    endfunction

    localparam t_tone_rom TONE_CURVE = f_tone_curve();

endpackage

`default_nettype wire

@@ design/bsa_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none

module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ design/bsa_tone_rom.sv @@
// One channel of tone mapping: clamp the sum to a curve index, registered ROM read.
`default_nettype none

module bsa_tone_rom (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [bsa_pkg::SUM_W-1:0]   i_sum,
    output logic      [bsa_pkg::BYTE_W-1:0]  o_byte
);

    logic [bsa_pkg::TONE_IDX_W-1:0] idx;

    // sum >> 16, saturated at the last entry
    always_comb begin
        if (|i_sum[bsa_pkg::SUM_W-1:bsa_pkg::TONE_SHIFT+bsa_pkg::TONE_IDX_W]) begin
            idx = bsa_pkg::TONE_MAX_IDX;
        end else begin
            idx = i_sum[bsa_pkg::TONE_SHIFT +: bsa_pkg::TONE_IDX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_byte <= bsa_pkg::TONE_CURVE[idx];
        end
    end

endmodule

`default_nettype wire

@@ design/bsa_splat.sv @@
// Splat datapath: operand products, per-corner contributions, saturating add.
`default_nettype none

module bsa_splat (
    input  wire logic                          i_clk,
    input  wire bsa_pkg::t_seq_ctl             i_ctl,
    input  wire logic [bsa_pkg::FRAC_W-1:0]    i_x_frac,
    input  wire logic [bsa_pkg::FRAC_W-1:0]    i_y_frac,
    input  wire logic [bsa_pkg::COLOR_W-1:0]   i_color_red,
    input  wire logic [bsa_pkg::COLOR_W-1:0]   i_color_green,
    input  wire logic [bsa_pkg::COLOR_W-1:0]   i_color_blue,
    input  wire logic [bsa_pkg::WEIGHT_W-1:0]  i_weight,
    input  wire logic [bsa_pkg::WORD_W-1:0]    i_sum,
    output logic      [bsa_pkg::WORD_W-1:0]    o_sum
);

    localparam int FW = bsa_pkg::FRAC_W;
    localparam int CW = bsa_pkg::CORNER_W;
    localparam int SW = bsa_pkg::SUM_W;

    logic [bsa_pkg::CW_W-1:0]  r_cw  [bsa_pkg::CH_NUM];
    logic [CW-1:0]             r_cwt [4];
    logic [SW-1:0]             r_add [bsa_pkg::CH_NUM];

    logic [FW:0]               fx_hi, fx_lo, fy_hi, fy_lo;
    logic [bsa_pkg::COLOR_W-1:0] color [bsa_pkg::CH_NUM];
    logic [CW-1:0]             corner_w;
    logic [bsa_pkg::PROD_W-1:0] prod [bsa_pkg::CH_NUM];
    logic [SW:0]               acc  [bsa_pkg::CH_NUM];

    assign fx_lo = {1'b0, i_x_frac};
    assign fy_lo = {1'b0, i_y_frac};
    assign fx_hi = (FW+1)'(1 << FW) - fx_lo;
    assign fy_hi = (FW+1)'(1 << FW) - fy_lo;

    assign color[0] = i_color_red;
    assign color[1] = i_color_green;
    assign color[2] = i_color_blue;

    always_comb begin
        unique case (i_ctl.corner)
            2'd0:    corner_w = r_cwt[0];
            2'd1:    corner_w = r_cwt[1];
            2'd2:    corner_w = r_cwt[2];
            default: corner_w = r_cwt[3];
        endcase
    end

    always_comb begin
        for (int c = 0; c < bsa_pkg::CH_NUM; c++) begin
            prod[c] = bsa_pkg::PROD_W'(r_cw[c]) * bsa_pkg::PROD_W'(corner_w);
            acc[c]  = {1'b0, i_sum[c*SW +: SW]} + {1'b0, r_add[c]};
            o_sum[c*SW +: SW] = acc[c][SW] ? '1 : acc[c][SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            for (int c = 0; c < bsa_pkg::CH_NUM; c++) begin
                r_cw[c] <= bsa_pkg::CW_W'(color[c]) * bsa_pkg::CW_W'(i_weight);
            end
            r_cwt[0] <= CW'(fx_hi) * CW'(fy_hi);
            r_cwt[1] <= CW'(fx_lo) * CW'(fy_hi);
            r_cwt[2] <= CW'(fx_hi) * CW'(fy_lo);
            r_cwt[3] <= CW'(fx_lo) * CW'(fy_lo);
        end
        // exact Q8.40 product truncated to Q8.24; always below 2^32
        if (i_ctl.mul_en) begin
            for (int c = 0; c < bsa_pkg::CH_NUM; c++) begin
                r_add[c] <= prod[c][16 +: SW];
            end
        end
    end

endmodule

`default_nettype wire

@@ design/bsa_seq.sv @@
// Sequencer: clear pass, item acceptance, corner walk and readout control.
`default_nettype none

module bsa_seq #(
    parameter int IMG_WIDTH  = bsa_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = bsa_pkg::IMG_HEIGHT_DEF
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_in_valid,
    output logic                                            o_in_ready,
    input  wire logic                                       i_func,
    input  wire logic [bsa_pkg::POS_W-1:0]                  i_x_pos,
    input  wire logic [bsa_pkg::POS_W-1:0]                  i_y_pos,
    input  wire logic [bsa_pkg::PIXIDX_W-1:0]               i_pixel_index,
    input  wire logic                                       i_out_free,
    output bsa_pkg::t_seq_ctl                               o_ctl,
    output logic [$clog2(IMG_WIDTH*IMG_HEIGHT)-1:0]         o_raddr,
    output logic [$clog2(IMG_WIDTH*IMG_HEIGHT)-1:0]         o_waddr
);

    localparam int NPIX   = IMG_WIDTH * IMG_HEIGHT;
    localparam int ADDR_W = $clog2(NPIX);
    localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(IMG_WIDTH);
    localparam logic [ADDR_W-1:0] LAST_PIX = ADDR_W'(NPIX - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLAT,
        ST_WLAST,
        ST_RD_ISSUE,
        ST_RD_OUT
    } t_state;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_cnt, n_clr_cnt;
    logic [ADDR_W-1:0]   r_base, n_base;
    logic [1:0]          r_corner, n_corner;
    logic                r_wr_pend;
    logic [ADDR_W-1:0]   r_wr_addr;
    logic [ADDR_W-1:0]   r_idx, n_idx;
    logic                r_oor, n_oor;

    logic [bsa_pkg::INT_W-1:0] xi, yi;
    logic                accept, drop, go;
    logic [ADDR_W-1:0]   base_in, corner_addr;

    assign xi = i_x_pos[bsa_pkg::POS_W-1:bsa_pkg::FRAC_W];
    assign yi = i_y_pos[bsa_pkg::POS_W-1:bsa_pkg::FRAC_W];

    assign o_in_ready = (r_state == ST_IDLE) || (r_state == ST_WLAST);
    assign accept     = i_in_valid && o_in_ready;
    assign drop       = (32'(xi) >= 32'(IMG_WIDTH - 1)) || (32'(yi) >= 32'(IMG_HEIGHT - 1));
    assign base_in    = ADDR_W'(32'(yi) * 32'(IMG_WIDTH) + 32'(xi));
    assign go         = (r_state == ST_RD_OUT) && i_out_free;

    always_comb begin
        unique case (r_corner)
            2'd0:    corner_addr = r_base;
            2'd1:    corner_addr = r_base + ADDR_W'(1);
            2'd2:    corner_addr = r_base + ROW_STEP;
            default: corner_addr = r_base + ROW_STEP + ADDR_W'(1);
        endcase
    end

    assign o_raddr = (r_state == ST_SPLAT) ? corner_addr : r_idx;

    always_comb begin
        priority if (r_state == ST_CLEAR) begin
            o_waddr = r_clr_cnt;
        end else if (r_wr_pend) begin
            o_waddr = r_wr_addr;
        end else begin
            o_waddr = r_idx;
        end
    end

    always_comb begin
        o_ctl         = '0;
        o_ctl.load    = accept;
        o_ctl.mul_en  = (r_state == ST_SPLAT);
        o_ctl.corner  = r_corner;
        o_ctl.acc_we  = r_wr_pend;
        o_ctl.zero_we = (r_state == ST_CLEAR) || (go && !r_oor);
        o_ctl.tone_en = go;
        o_ctl.oor     = r_oor;
    end

    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        n_base    = r_base;
        n_corner  = r_corner;
        n_idx     = r_idx;
        n_oor     = r_oor;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_cnt = r_clr_cnt + ADDR_W'(1);
                if (r_clr_cnt == LAST_PIX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE, ST_WLAST: begin
                n_state = ST_IDLE;
                if (accept) begin
                    n_idx = ADDR_W'(i_pixel_index);
                    n_oor = 32'(i_pixel_index) >= 32'(NPIX);
                    if (i_func == bsa_pkg::FUNC_READ) begin
                        n_state = ST_RD_ISSUE;
                    end else if (!drop) begin
                        n_state  = ST_SPLAT;
                        n_base   = base_in;
                        n_corner = 2'd0;
                    end
                end
            end
            ST_SPLAT: begin
                n_corner = r_corner + 2'd1;
                if (r_corner == 2'd3) begin
                    n_state = ST_WLAST;
                end
            end
            ST_RD_ISSUE: begin
                n_state = ST_RD_OUT;
            end
            ST_RD_OUT: begin
                if (go) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_wr_pend <= (r_state == ST_SPLAT);
        end
        r_base    <= n_base;
        r_corner  <= n_corner;
        r_idx     <= n_idx;
        r_oor     <= n_oor;
        r_wr_addr <= corner_addr;
    end

endmodule

`default_nettype wire

@@ design/bilinear_splat_accumulator.sv @@
// Top level of the bilinear splat accumulator with tone mapped readout.
`default_nettype none

// Keeps an IMG_WIDTH x IMG_HEIGHT image of three Q8.24 saturating sums in one
// RAM word per pixel (red low, blue high). A splat item (tuser = 0) adds
// colour * weight * bilinear corner weight into the four pixels around its
// Q9.8 position, one read-modify-write per pixel through the RAM's single
// read and single write port; splats whose integer position reaches the last
// column or row are dropped. A readout item (tuser = 1) returns the three
// channels through the exponential tone curve and zeroes the pixel; an index
// past the image returns zeros and leaves the image alone. A splat holds the
// input through its accept and four corner reads (the last write-back overlaps
// the next accept), a dropped splat only through its accept, and a readout
// through its accept, the RAM read and the tone lookup, plus any time the
// output register is still held by the sink. The finished result waits in the
// output register while the next item is taken. After reset a clearing pass
// writes zero to every pixel, one a cycle; tready stays low during it.
module bilinear_splat_accumulator #(
    parameter int IMG_WIDTH  = bsa_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = bsa_pkg::IMG_HEIGHT_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // x_pos[16:0], y_pos[33:17], color_red[49:34], color_green[65:50],
    // color_blue[81:66], weight[97:82], pixel_index[115:98], zero[119:116]
    input  wire logic [bsa_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // func: 0 splat, 1 readout and clear
    input  wire logic                               i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic [bsa_pkg::OUT_TDATA_W-1:0]         o_m_axis_tdata
);

    localparam int NPIX   = IMG_WIDTH * IMG_HEIGHT;
    localparam int ADDR_W = $clog2(NPIX);
    localparam int SW     = bsa_pkg::SUM_W;

    // unpacked input fields
    logic [bsa_pkg::POS_W-1:0]    x_pos, y_pos;
    logic [bsa_pkg::COLOR_W-1:0]  color_red, color_green, color_blue;
    logic [bsa_pkg::WEIGHT_W-1:0] weight;
    logic [bsa_pkg::PIXIDX_W-1:0] pixel_index;

    assign x_pos       = i_s_axis_tdata[16:0];
    assign y_pos       = i_s_axis_tdata[33:17];
    assign color_red   = i_s_axis_tdata[49:34];
    assign color_green = i_s_axis_tdata[65:50];
    assign color_blue  = i_s_axis_tdata[81:66];
    assign weight      = i_s_axis_tdata[97:82];
    assign pixel_index = i_s_axis_tdata[115:98];

    bsa_pkg::t_seq_ctl            ctl;
    logic [ADDR_W-1:0]            raddr, waddr;
    logic [bsa_pkg::WORD_W-1:0]   rdata, splat_word, wdata, tone_sum;
    logic                         r_out_valid;
    logic                         out_free;

    assign out_free = !r_out_valid || i_m_axis_tready;

    bsa_seq #(
        .IMG_WIDTH  (IMG_WIDTH),
        .IMG_HEIGHT (IMG_HEIGHT)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_s_axis_tvalid),
        .o_in_ready    (o_s_axis_tready),
        .i_func        (i_s_axis_tuser),
        .i_x_pos       (x_pos),
        .i_y_pos       (y_pos),
        .i_pixel_index (pixel_index),
        .i_out_free    (out_free),
        .o_ctl         (ctl),
        .o_raddr       (raddr),
        .o_waddr       (waddr)
    );

    bsa_splat u_splat (
        .i_clk         (i_clk),
        .i_ctl         (ctl),
        .i_x_frac      (x_pos[bsa_pkg::FRAC_W-1:0]),
        .i_y_frac      (y_pos[bsa_pkg::FRAC_W-1:0]),
        .i_color_red   (color_red),
        .i_color_green (color_green),
        .i_color_blue  (color_blue),
        .i_weight      (weight),
        .i_sum         (rdata),
        .o_sum         (splat_word)
    );

    // accumulate write-back, otherwise a zero word (clear pass / readout)
    assign wdata = ctl.acc_we ? splat_word : '0;

    bsa_ram #(
        .WIDTH (bsa_pkg::WORD_W),
        .DEPTH (NPIX)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (ctl.acc_we || ctl.zero_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // tone curve maps a zero sum to zero, so out-of-range reads use zero sums
    assign tone_sum = ctl.oor ? '0 : rdata;

    for (genvar c = 0; c < bsa_pkg::CH_NUM; c++) begin : g_tone
        bsa_tone_rom u_tone (
            .i_clk  (i_clk),
            .i_en   (ctl.tone_en),
            .i_sum  (tone_sum[c*SW +: SW]),
            .o_byte (o_m_axis_tdata[c*bsa_pkg::BYTE_W +: bsa_pkg::BYTE_W])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.tone_en) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;

endmodule

`default_nettype wire

@@ design/bsa_checker.sv @@
// Port-level checks on the splat accumulator, bound to its top level.
`default_nettype none

module bsa_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    input  wire logic                               o_s_axis_tready,
    input  wire logic                               i_s_axis_tuser,
    input  wire logic                               o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    input  wire logic [bsa_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    logic s_acc;
    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;

    // clearing pass follows every reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("input ready right after reset");

    // a splat never produces a result
    a_splat_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && !i_s_axis_tuser && !o_m_axis_tvalid |=> !o_m_axis_tvalid)
        else $error("result appeared after a splat");

    // readout holds the input while it fetches the pixel
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && i_s_axis_tuser |=> !o_s_axis_tready)
        else $error("input ready during readout fetch");

    // stalled result keeps its bytes
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind bilinear_splat_accumulator bsa_checker u_bsa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

@@ verif/bilinear_splat_accumulator_tb.sv @@
// Testbench for the bilinear splat accumulator: directed and random splats and readouts
module bilinear_splat_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IMG_W        = bsa_pkg::IMG_WIDTH_DEF;
    localparam int IMG_H        = bsa_pkg::IMG_HEIGHT_DEF;
    localparam int NPIX         = IMG_W * IMG_H;
    // clearing pass after reset keeps tready low while it zeroes all NPIX pixels
    localparam int STALL_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 32;
    localparam int MAX_PRINTS   = 40;

    // one input item, fields as in tdata plus func on tuser
    typedef struct {
        logic                           func;
        logic [bsa_pkg::POS_W-1:0]      x_pos;
        logic [bsa_pkg::POS_W-1:0]      y_pos;
        logic [bsa_pkg::COLOR_W-1:0]    red;
        logic [bsa_pkg::COLOR_W-1:0]    green;
        logic [bsa_pkg::COLOR_W-1:0]    blue;
        logic [bsa_pkg::WEIGHT_W-1:0]   weight;
        logic [bsa_pkg::PIXIDX_W-1:0]   pixel_index;
    } t_splat_cmd;

    typedef struct {
        logic [bsa_pkg::BYTE_W-1:0] red;
        logic [bsa_pkg::BYTE_W-1:0] green;
        logic [bsa_pkg::BYTE_W-1:0] blue;
    } t_rgb8;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    // x_pos, y_pos, color_red, color_green, color_blue, weight, pixel_index, zero pad
    logic [bsa_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata = '0;
    // func
    logic                             i_s_axis_tuser = bsa_pkg::FUNC_SPLAT;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    // out_red, out_green, out_blue
    logic [bsa_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata;

    // predicted image: three Q8.24 sums per pixel, zero after reset
    bit [bsa_pkg::SUM_W-1:0]  sum_r [NPIX];
    bit [bsa_pkg::SUM_W-1:0]  sum_g [NPIX];
    bit [bsa_pkg::SUM_W-1:0]  sum_b [NPIX];
    bit [bsa_pkg::BYTE_W-1:0] tone_lut [bsa_pkg::TONE_LEN];

    t_rgb8 readout_q [$];
    int    fail_count  = 0;
    int    items_sent  = 0;
    int    idle_cycles = 0;
    bit    no_idle     = 1'b0;

    bilinear_splat_accumulator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // exp(-11/2560) by a five term series in Q0.40, then the curve by repeated
    // multiplication in Q0.32
    function automatic void build_tone_lut();
        longint unsigned term;
        longint unsigned e;
        longint unsigned ratio;
        longint unsigned v;
        longint unsigned t;
        term = 64'd1 << 40;
        e    = term;
        for (int k = 1; k <= 5; k++) begin
            term = (term * 64'd11) / longint'(2560 * k);
            if (k % 2 == 1) begin
                e = e - term;
            end else begin
                e = e + term;
            end
        end
        ratio = (e + 64'd128) >> 8;
        v     = 64'd1 << 32;
        for (int i = 0; i < bsa_pkg::TONE_LEN; i++) begin
            if (i != 0) begin
                v = (v * ratio + (64'd1 << 31)) >> 32;
            end
            t = (64'd255 * ((64'd1 << 32) - v)) >> 32;
            tone_lut[i] = (t > 64'd255) ? 8'hFF : t[7:0];
        end
    endfunction

    function automatic bit [bsa_pkg::SUM_W-1:0] sat_sum(bit [bsa_pkg::SUM_W-1:0] cur,
                                                        longint unsigned add);
        longint unsigned s;
        s = longint'(cur) + add;
        return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[bsa_pkg::SUM_W-1:0];
    endfunction

    function automatic void deposit(int pix, longint unsigned corner, t_splat_cmd c);
        longint unsigned cw;
        cw = corner * longint'(c.weight);
        sum_r[pix] = sat_sum(sum_r[pix], (longint'(c.red) * cw) >> 16);
        sum_g[pix] = sat_sum(sum_g[pix], (longint'(c.green) * cw) >> 16);
        sum_b[pix] = sat_sum(sum_b[pix], (longint'(c.blue) * cw) >> 16);
    endfunction

    function automatic bit [bsa_pkg::BYTE_W-1:0] tone_of(bit [bsa_pkg::SUM_W-1:0] s);
        int ti;
        ti = int'(s >> bsa_pkg::TONE_SHIFT);
        if (ti > bsa_pkg::TONE_LEN - 1) begin
            ti = bsa_pkg::TONE_LEN - 1;
        end
        return tone_lut[ti];
    endfunction

    // update the image for one accepted item, queue the readout it causes
    function automatic void predict(t_splat_cmd c);
        int              xi;
        int              yi;
        int              base;
        longint unsigned fx;
        longint unsigned fy;
        t_rgb8           px;
        if (c.func == bsa_pkg::FUNC_SPLAT) begin
            xi = int'(c.x_pos >> bsa_pkg::FRAC_W);
            yi = int'(c.y_pos >> bsa_pkg::FRAC_W);
            fx = longint'(c.x_pos[bsa_pkg::FRAC_W-1:0]);
            fy = longint'(c.y_pos[bsa_pkg::FRAC_W-1:0]);
            // last column or row: dropped
            if (xi >= IMG_W - 1 || yi >= IMG_H - 1) begin
                return;
            end
            base = yi * IMG_W + xi;
            deposit(base,             (256 - fx) * (256 - fy), c);
            deposit(base + 1,         fx * (256 - fy),         c);
            deposit(base + IMG_W,     (256 - fx) * fy,         c);
            deposit(base + IMG_W + 1, fx * fy,                 c);
        end else begin
            if (c.pixel_index >= NPIX) begin
                // past the image: zeros, image untouched
                px = '{red: '0, green: '0, blue: '0};
            end else begin
                px.red   = tone_of(sum_r[c.pixel_index]);
                px.green = tone_of(sum_g[c.pixel_index]);
                px.blue  = tone_of(sum_b[c.pixel_index]);
                sum_r[c.pixel_index] = '0;
                sum_g[c.pixel_index] = '0;
                sum_b[c.pixel_index] = '0;
            end
            readout_q.push_back(px);
        end
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string what, int got, int want);
        if (fail_count < MAX_PRINTS) begin
            $display("%0t: mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        end
        fail_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_rgb8 want;
        t_rgb8 got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.red   = o_m_axis_tdata[7:0];
            got.green = o_m_axis_tdata[15:8];
            got.blue  = o_m_axis_tdata[23:16];
            if (readout_q.size() == 0) begin
                report_mismatch("result with no readout pending", int'(o_m_axis_tdata), -1);
            end else begin
                want = readout_q.pop_front();
                if (got.red !== want.red) begin
                    report_mismatch("out_red", int'(got.red), int'(want.red));
                end
                if (got.green !== want.green) begin
                    report_mismatch("out_green", int'(got.green), int'(want.green));
                end
                if (got.blue !== want.blue) begin
                    report_mismatch("out_blue", int'(got.blue), int'(want.blue));
                end
            end
        end
    end

    // sink stalls about 14% of cycles unless in the no-idle stretch
    always @(posedge i_clk) begin
        i_m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 14);
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- stimulus

    // tvalid stays high between back-to-back items
    task automatic send_item(t_splat_cmd c);
        if (!no_idle && $urandom_range(0, 99) < 14) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= c.func;
        i_s_axis_tdata  <= bsa_pkg::IN_TDATA_W'({c.pixel_index, c.weight, c.blue, c.green,
                                                 c.red, c.y_pos, c.x_pos});
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_sent++;
        predict(c);
    endtask

    // unused fields carry random values too
    function automatic t_splat_cmd random_cmd();
        t_splat_cmd c;
        c.func        = $urandom_range(0, 1) ? bsa_pkg::FUNC_READ : bsa_pkg::FUNC_SPLAT;
        c.x_pos       = bsa_pkg::POS_W'($urandom_range(0, 131071));
        c.y_pos       = bsa_pkg::POS_W'($urandom_range(0, 131071));
        c.red         = bsa_pkg::COLOR_W'($urandom);
        c.green       = bsa_pkg::COLOR_W'($urandom);
        c.blue        = bsa_pkg::COLOR_W'($urandom);
        c.weight      = bsa_pkg::WEIGHT_W'($urandom);
        c.pixel_index = bsa_pkg::PIXIDX_W'($urandom_range(0, 262143));
        return c;
    endfunction

    function automatic t_splat_cmd splat_cmd(int x, int y, int r, int g, int b, int w);
        t_splat_cmd c;
        c        = random_cmd();
        c.func   = bsa_pkg::FUNC_SPLAT;
        c.x_pos  = bsa_pkg::POS_W'(x);
        c.y_pos  = bsa_pkg::POS_W'(y);
        c.red    = bsa_pkg::COLOR_W'(r);
        c.green  = bsa_pkg::COLOR_W'(g);
        c.blue   = bsa_pkg::COLOR_W'(b);
        c.weight = bsa_pkg::WEIGHT_W'(w);
        return c;
    endfunction

    function automatic t_splat_cmd read_cmd(int pix);
        t_splat_cmd c;
        c             = random_cmd();
        c.func        = bsa_pkg::FUNC_READ;
        c.pixel_index = bsa_pkg::PIXIDX_W'(pix);
        return c;
    endfunction

    function automatic int pick_color();
        case ($urandom_range(0, 7))
            0: begin
                return 0;
            end
            1: begin
                return 16'hFFFF;
            end
            default: begin
                return $urandom_range(0, 65535);
            end
        endcase
    endfunction

    task automatic test_empty_readout();
        send_item(read_cmd(0));
        send_item(read_cmd(NPIX - 1));
    endtask

    task automatic test_out_of_range();
        send_item(read_cmd(NPIX));
        send_item(read_cmd(262143));
    endtask

    // splats whose integer position sits on the last column or row do nothing
    task automatic test_edge_drop();
        send_item(splat_cmd(((IMG_W - 1) << 8) | 128, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0200));
        send_item(splat_cmd(0, ((IMG_H - 1) << 8) | 255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0200));
        send_item(splat_cmd(131071, 131071, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(read_cmd(IMG_W - 1));
        send_item(read_cmd((IMG_H - 1) * IMG_W));
    endtask

    // largest valid position with full fractions, then whole-pixel splat at origin
    task automatic test_corner_weights();
        int base;
        base = (IMG_H - 2) * IMG_W + IMG_W - 2;
        send_item(splat_cmd(((IMG_W - 2) << 8) | 255, ((IMG_H - 2) << 8) | 255,
                            16'h8000, 16'hFFFF, 16'h0001, 16'h0100));
        send_item(read_cmd(base));
        send_item(read_cmd(base + 1));
        send_item(read_cmd(base + IMG_W));
        send_item(read_cmd(base + IMG_W + 1));
        send_item(splat_cmd(0, 0, 16'h4000, 16'hC000, 16'h1234, 16'h0200));
        send_item(read_cmd(0));
        send_item(read_cmd(1));
    endtask

    // two full splats overflow the sums; zero weight and zero colour add nothing
    task automatic test_saturation();
        send_item(splat_cmd(5 << 8, 3 << 8, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(splat_cmd(5 << 8, 3 << 8, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(read_cmd(3 * IMG_W + 5));
        send_item(splat_cmd((7 << 8) | 77, (9 << 8) | 33, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0));
        send_item(splat_cmd((7 << 8) | 77, (9 << 8) | 33, 0, 0, 0, 16'hFFFF));
        send_item(read_cmd(9 * IMG_W + 8));
    endtask

    // a few splats in a small patch, then read most of the 3x3 around it;
    // unread pixels carry over into later patches
    task automatic run_patch();
        int         col;
        int         row;
        int         wmode;
        t_splat_cmd c;
        col   = $urandom_range(0, IMG_W - 2);
        row   = $urandom_range(0, IMG_H - 2);
        wmode = $urandom_range(0, 9);
        if ($urandom_range(0, 9) == 0) begin
            col = $urandom_range(IMG_W - 3, IMG_W - 1);
        end
        if ($urandom_range(0, 9) == 0) begin
            row = $urandom_range(IMG_H - 3, IMG_H - 1);
        end
        repeat ($urandom_range(1, 6)) begin
            c = splat_cmd(((col + $urandom_range(0, 1)) << 8) | $urandom_range(0, 255),
                          ((row + $urandom_range(0, 1)) << 8) | $urandom_range(0, 255),
                          pick_color(), pick_color(), pick_color(), 0);
            // mostly weights that keep the tone index off the clamp
            if (wmode < 5) begin
                c.weight = bsa_pkg::WEIGHT_W'($urandom_range(0, 1023));
            end else if (wmode < 8) begin
                c.weight = bsa_pkg::WEIGHT_W'($urandom_range(0, 8191));
            end else begin
                c.weight = bsa_pkg::WEIGHT_W'($urandom);
            end
            send_item(c);
        end
        for (int dy = 0; dy < 3; dy++) begin
            for (int dx = 0; dx < 3; dx++) begin
                if (col + dx < IMG_W && row + dy < IMG_H && $urandom_range(0, 99) < 85) begin
                    send_item(read_cmd((row + dy) * IMG_W + col + dx));
                end
            end
        end
    endtask

    // stray item with all fields random
    task automatic run_noise();
        t_splat_cmd c;
        c = random_cmd();
        if (c.func == bsa_pkg::FUNC_READ && $urandom_range(0, 1)) begin
            c.pixel_index = bsa_pkg::PIXIDX_W'($urandom_range(0, NPIX - 1));
        end
        send_item(c);
    endtask

    task automatic test_random_patches(int budget);
        int first;
        first = items_sent;
        while (items_sent - first < budget) begin
            if ($urandom_range(0, 99) < 80) begin
                run_patch();
            end else begin
                run_noise();
            end
        end
    endtask

    task automatic test_no_idle_burst(int budget);
        no_idle = 1'b1;
        test_random_patches(budget);
        no_idle = 1'b0;
    endtask

    initial begin
        build_tone_lut();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_readout();
        test_out_of_range();
        test_edge_drop();
        test_corner_weights();
        test_saturation();
        test_random_patches(600);
        test_no_idle_burst(300);
        test_random_patches(550);

        i_s_axis_tvalid <= 1'b0;
        while (readout_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/bsa_pkg.sv
design/bsa_ram.sv
design/bsa_tone_rom.sv
design/bsa_splat.sv
design/bsa_seq.sv
design/bilinear_splat_accumulator.sv
design/bsa_checker.sv
verif/bilinear_splat_accumulator_tb.sv
